### sv/skvt_pkg.sv
// Package for the sorted key/value table: item types, cell types and codes.
// No dependencies; every other file in this folder imports it.
`default_nettype none

package skvt_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Input opcodes.
    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_DUMP   = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // Commands broadcast to every cell of the chain.
    localparam logic [2:0] CMD_HOLD   = 3'd0;
    localparam logic [2:0] CMD_UPDATE = 3'd1;
    localparam logic [2:0] CMD_INSERT = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_ROTATE = 3'd4;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0]   out_key;
        logic signed [VALUE_W-1:0] out_value;
        logic                      found;
        logic [COUNT_W-1:0]        entry_count;
        logic [1:0]                status;
        logic                      last;
    } t_out_item;

    // Contents of one cell.
    typedef struct packed {
        logic                      valid;
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } t_entry;

    // Command and operands shared by all cells in one cycle.
    typedef struct packed {
        logic [2:0]                op;
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } t_cell_cmd;

    // Compare flags a cell reports for the broadcast key.
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_cell_flags;

endpackage

`default_nettype wire

### sv/skvt_cell.sv
// One cell of the sorted chain: holds one pair and shifts with its neighbors.
// Depends on skvt_pkg for the entry, command and flag types.
`default_nettype none

module skvt_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire skvt_pkg::t_cell_cmd   i_cmd,
    input  wire skvt_pkg::t_entry      i_left,
    input  wire logic                  i_left_gt,
    input  wire skvt_pkg::t_entry      i_right,
    input  wire skvt_pkg::t_entry      i_head,
    output skvt_pkg::t_entry           o_entry,
    output skvt_pkg::t_cell_flags      o_flags
);
    import skvt_pkg::*;

    logic                      r_valid;
    logic signed [KEY_W-1:0]   r_key;
    logic signed [VALUE_W-1:0] r_value;
    t_entry                    n_entry;
    t_cell_flags               flags;

    assign o_entry = '{valid: r_valid, key: r_key, value: r_value};

    // Only a valid cell can match or sort below the broadcast key.
    always_comb begin
        flags.lt = r_valid && (r_key < i_cmd.key);
        flags.eq = r_valid && (r_key == i_cmd.key);
        flags.gt = !flags.lt && !flags.eq;
    end

    assign o_flags = flags;

    // Next contents: keep, overwrite, or take a neighbor's pair.
    always_comb begin
        n_entry = o_entry;
        unique case (i_cmd.op)
            CMD_UPDATE: begin
                if (flags.eq) begin
                    n_entry.value = i_cmd.value;
                end
            end
            CMD_INSERT: begin
                // The first cell above the key takes the new pair, later ones shift up.
                if (flags.gt) begin
                    if (i_left_gt) begin
                        n_entry = i_left;
                    end else begin
                        n_entry = '{valid: 1'b1, key: i_cmd.key, value: i_cmd.value};
                    end
                end
            end
            CMD_REMOVE: begin
                // The matching cell and everything above it shift down.
                if (!flags.lt) begin
                    n_entry = i_right;
                end
            end
            CMD_ROTATE: begin
                // The last valid cell wraps around to the head pair.
                if (r_valid) begin
                    n_entry = i_right.valid ? i_right : i_head;
                end
            end
            default: begin
                n_entry = o_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_entry.key;
        r_value <= n_entry.value;
    end

endmodule

`default_nettype wire

### sv/sorted_key_value_table_unit.sv
// Sorted key/value table. The pairs sit in a chain of CAPACITY cells kept in
// ascending signed key order and packed from cell 0. On a put, get or remove all
// cells compare the key at once and shift by one place on an insert or a delete.
// A dump of n pairs gives n results, one result per cycle while the output
// register is free or being read, because the chain rotates one place per result
// and the head cell is emitted; a dump of an empty table gives one result.
// Results leave through an output register, and a new item is taken as soon as
// that register is free or being read, except while a dump is still emitting.
// Depends on skvt_pkg and skvt_cell.
`default_nettype none

module sorted_key_value_table_unit #(
    parameter int CAPACITY = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire skvt_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output skvt_pkg::t_out_item       o_out_item
);
    import skvt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic               r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_left, n_left;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_item, n_out_item;

    t_cell_cmd          cmd;
    t_entry             entries [CAPACITY];
    t_cell_flags        flags [CAPACITY];
    logic               out_free;
    logic               accept;
    logic               any_match;
    logic               is_full;
    logic [VALUE_W-1:0] match_value;
    logic               load_out;

    // Chain of cells, each wired to its two neighbors and to the head cell.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry left_entry;
        t_entry right_entry;
        logic   left_gt;

        if (g == 0) begin : g_first
            assign left_entry = '0;
            assign left_gt    = 1'b0;
        end else begin : g_inner
            assign left_entry = entries[g-1];
            assign left_gt    = flags[g-1].gt;
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_body
            assign right_entry = entries[g+1];
        end

        skvt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (cmd),
            .i_left    (left_entry),
            .i_left_gt (left_gt),
            .i_right   (right_entry),
            .i_head    (entries[0]),
            .o_entry   (entries[g]),
            .o_flags   (flags[g])
        );
    end

    // Gather the lookup result; at most one cell matches.
    always_comb begin
        any_match   = 1'b0;
        match_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            any_match   = any_match | flags[i].eq;
            match_value = match_value | (flags[i].eq ? entries[i].value : '0);
        end
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign is_full    = (r_count == CNT_W'(CAPACITY));

    // Command decode and result formation.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_left     = r_left;
        load_out   = 1'b0;
        n_out_item = r_out_item;
        cmd        = '{op: CMD_HOLD, key: i_in_item.key, value: i_in_item.value};

        if (r_state == ST_IDLE) begin
            if (accept) begin
                load_out               = 1'b1;
                n_out_item.out_key     = i_in_item.key;
                n_out_item.out_value   = '0;
                n_out_item.found       = any_match;
                n_out_item.status      = STAT_OK;
                n_out_item.last        = 1'b1;
                unique case (i_in_item.opcode)
                    OP_PUT: begin
                        if (any_match) begin
                            cmd.op = CMD_UPDATE;
                        end else if (is_full) begin
                            n_out_item.status = STAT_FULL;
                        end else begin
                            cmd.op  = CMD_INSERT;
                            n_count = CNT_W'(r_count + 1'b1);
                        end
                    end
                    OP_GET: begin
                        n_out_item.out_value = match_value;
                    end
                    OP_REMOVE: begin
                        if (any_match) begin
                            cmd.op  = CMD_REMOVE;
                            n_count = CNT_W'(r_count - 1'b1);
                        end
                    end
                    OP_DUMP: begin
                        if (r_count == '0) begin
                            n_out_item.out_key = '0;
                            n_out_item.found   = 1'b0;
                            n_out_item.status  = STAT_EMPTY;
                        end else begin
                            // Emit the head pair now and rotate the chain.
                            cmd.op               = CMD_ROTATE;
                            n_out_item.out_key   = entries[0].key;
                            n_out_item.out_value = entries[0].value;
                            n_out_item.found     = 1'b1;
                            n_out_item.last      = (r_count == CNT_W'(1));
                            n_left               = CNT_W'(r_count - 1'b1);
                            if (r_count != CNT_W'(1)) begin
                                n_state = ST_DUMP;
                            end
                        end
                    end
                    default: begin
                        n_out_item.status = STAT_OK;
                    end
                endcase
                n_out_item.entry_count = COUNT_W'(n_count);
            end
        end else if (out_free) begin
            // Dump in progress: one pair per free output slot.
            load_out               = 1'b1;
            cmd.op                 = CMD_ROTATE;
            n_out_item.out_key     = entries[0].key;
            n_out_item.out_value   = entries[0].value;
            n_out_item.found       = 1'b1;
            n_out_item.entry_count = COUNT_W'(r_count);
            n_out_item.status      = STAT_OK;
            n_out_item.last        = (r_left == CNT_W'(1));
            n_left                 = CNT_W'(r_left - 1'b1);
            if (r_left == CNT_W'(1)) begin
                n_state = ST_IDLE;
            end
        end
    end

    // Output register valid.
    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

### sv/skvt_check.sv
// Port-level checker for the sorted key/value table, and its bind to the top level.
// Depends on skvt_pkg and sorted_key_value_table_unit.
`default_nettype none

module skvt_check #(
    parameter int CAPACITY = 16
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire skvt_pkg::t_out_item  o_out_item
);
    import skvt_pkg::*;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // No new item is taken while a dump is still emitting.
    a_no_accept_mid_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last |-> !o_in_ready)
        else $error("input ready during a dump");

    // A refused put reports no match and no value.
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == STAT_FULL)
        |-> !o_out_item.found && (o_out_item.out_value == '0))
        else $error("bad full result");

    // An empty dump is a single final result with a count of zero.
    a_empty_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == STAT_EMPTY)
        |-> o_out_item.last && (o_out_item.entry_count == '0))
        else $error("bad empty dump result");

    // The count never exceeds the capacity where the field can show it.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CAPACITY > 31) || (int'(o_out_item.entry_count) <= CAPACITY))
        else $error("entry count beyond capacity");

endmodule

bind sorted_key_value_table_unit skvt_check #(
    .CAPACITY (CAPACITY)
) u_skvt_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

### dv/sorted_key_value_table_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_key_value_table_unit: directed and random
// put/get/remove/dump items with random idling on both channels.
// Depends on skvt_pkg and the RTL of the table.

module sorted_key_value_table_unit_tb;

    import skvt_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 80;
    localparam int POOL_SIZE    = 24;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 40;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    sorted_key_value_table_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // Clock: 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the table contents, kept in slot order.
    logic                      shadow_used [CAPACITY];
    logic signed [KEY_W-1:0]   shadow_key  [CAPACITY];
    logic signed [VALUE_W-1:0] shadow_value[CAPACITY];

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    logic signed [KEY_W-1:0] key_pool[POOL_SIZE];

    int  mismatches;
    int  results_checked;
    int  put_count, get_count, remove_count, dump_count;
    int  full_refusals, empty_dumps;
    logic in_taken;

    // Driver and receiver pacing state.
    int burst_left;
    int gap_left;
    int ready_mode;
    int mode_left;
    int stall_phase;

    function automatic int stored_pairs();
        int n;
        n = 0;
        for (int i = 0; i < CAPACITY; i++)
            if (shadow_used[i])
                n++;
        return n;
    endfunction

    function automatic int slot_of(logic signed [KEY_W-1:0] key);
        for (int i = 0; i < CAPACITY; i++)
            if (shadow_used[i] && shadow_key[i] == key)
                return i;
        return -1;
    endfunction

    // Queue one expected result; the count is taken after the table update.
    function automatic void expect_result(logic signed [KEY_W-1:0] key,
                                          logic signed [VALUE_W-1:0] value,
                                          logic found, logic [1:0] status,
                                          logic last);
        t_out_item r;
        r.out_key     = key;
        r.out_value   = value;
        r.found       = found;
        r.entry_count = COUNT_W'(stored_pairs());
        r.status      = status;
        r.last        = last;
        expected_results.push_back(r);
    endfunction

    // Apply one accepted item to the shadow table and queue its results.
    function automatic void apply_table_op(t_in_item it);
        int slot;
        int free_slot;
        int n;
        int j;
        logic signed [KEY_W-1:0]   sorted_key  [CAPACITY];
        logic signed [VALUE_W-1:0] sorted_value[CAPACITY];
        slot = slot_of(it.key);
        free_slot = -1;
        n = 0;
        case (it.opcode)
            OP_PUT: begin
                put_count++;
                if (slot >= 0) begin
                    shadow_value[slot] = it.value;
                    expect_result(it.key, '0, 1'b1, STAT_OK, 1'b1);
                end else begin
                    for (int i = CAPACITY - 1; i >= 0; i--)
                        if (!shadow_used[i])
                            free_slot = i;
                    if (free_slot >= 0) begin
                        shadow_used[free_slot]  = 1'b1;
                        shadow_key[free_slot]   = it.key;
                        shadow_value[free_slot] = it.value;
                        expect_result(it.key, '0, 1'b0, STAT_OK, 1'b1);
                    end else begin
                        full_refusals++;
                        expect_result(it.key, '0, 1'b0, STAT_FULL, 1'b1);
                    end
                end
            end
            OP_GET: begin
                get_count++;
                if (slot >= 0)
                    expect_result(it.key, shadow_value[slot], 1'b1, STAT_OK, 1'b1);
                else
                    expect_result(it.key, '0, 1'b0, STAT_OK, 1'b1);
            end
            OP_REMOVE: begin
                remove_count++;
                if (slot >= 0)
                    shadow_used[slot] = 1'b0;
                expect_result(it.key, '0, slot >= 0, STAT_OK, 1'b1);
            end
            OP_DUMP: begin
                dump_count++;
                // Insertion sort of the stored pairs by signed key.
                for (int i = 0; i < CAPACITY; i++) begin
                    if (shadow_used[i]) begin
                        j = n;
                        while (j > 0 && shadow_key[i] < sorted_key[j-1]) begin
                            sorted_key[j]   = sorted_key[j-1];
                            sorted_value[j] = sorted_value[j-1];
                            j--;
                        end
                        sorted_key[j]   = shadow_key[i];
                        sorted_value[j] = shadow_value[i];
                        n++;
                    end
                end
                if (n == 0) begin
                    empty_dumps++;
                    expect_result('0, '0, 1'b0, STAT_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        expect_result(sorted_key[i], sorted_value[i], 1'b1, STAT_OK,
                                      i == n - 1);
                end
            end
        endcase
    endfunction

    // Compare one accepted result with the oldest expectation.
    function automatic void check_result(t_out_item got);
        t_out_item want;
        string     bad;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("ERROR %0t: unexpected result key=%0d value=%0d found=%0b count=%0d status=%0d last=%0b",
                         $time, got.out_key, got.out_value, got.found, got.entry_count,
                         got.status, got.last);
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        bad = "";
        if (got.out_key !== want.out_key)         bad = {bad, " out_key"};
        if (got.out_value !== want.out_value)     bad = {bad, " out_value"};
        if (got.found !== want.found)             bad = {bad, " found"};
        if (got.entry_count !== want.entry_count) bad = {bad, " entry_count"};
        if (got.status !== want.status)           bad = {bad, " status"};
        if (got.last !== want.last)               bad = {bad, " last"};
        if (bad != "") begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("ERROR %0t: mismatch in%s", $time, bad);
                $display("  expected key=%0d value=%0d found=%0b count=%0d status=%0d last=%0b",
                         want.out_key, want.out_value, want.found, want.entry_count,
                         want.status, want.last);
                $display("  actual   key=%0d value=%0d found=%0b count=%0d status=%0d last=%0b",
                         got.out_key, got.out_value, got.found, got.entry_count,
                         got.status, got.last);
            end
        end
    endfunction

    function automatic void queue_item(logic [1:0] opcode, logic signed [KEY_W-1:0] key,
                                       logic signed [VALUE_W-1:0] value);
        t_in_item it;
        it.opcode = opcode;
        it.key    = key;
        it.value  = value;
        pending_items.push_back(it);
    endfunction

    // Mostly keys from a small pool so that hits, overwrites and a full table occur.
    function automatic logic signed [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // Monitor: checks each result before predicting the item taken at the same edge.
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                check_result(o_out_item);
            if (i_in_valid && o_in_ready) begin
                apply_table_op(i_in_item);
                in_taken = 1'b1;
            end
        end
    end

    // Driver: bursts of items with random gaps, and a receiver stall pattern.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken)
                void'(pending_items.pop_front());
            if (i_in_valid && !in_taken) begin
                // Item still waiting for acceptance: hold it.
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_item  <= pending_items[0];
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end

            // The receiver switches between randomly chosen stall modes.
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 64);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (stall_phase % 5) >= 2;
            endcase
            stall_phase++;
        end
    end

    // Main sequence: build the stimulus, reset, wait for all results, report.
    initial begin
        int generated;
        int kind;
        int start;
        logic fill_first;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_ready = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
            shadow_used[i] = 1'b0;

        // Directed: empty table, key extremes, overwrite, misses, drain to empty.
        queue_item(OP_DUMP,   '0, '0);
        queue_item(OP_GET,    '0, 32'sd77);
        queue_item(OP_REMOVE, 32'sd5, '0);
        queue_item(OP_PUT,    KEY_MIN, KEY_MAX);
        queue_item(OP_PUT,    KEY_MAX, KEY_MIN);
        queue_item(OP_PUT,    '0, '0);
        queue_item(OP_PUT,    -32'sd1, -32'sd1);
        queue_item(OP_PUT,    32'sd1, 32'sd1);
        queue_item(OP_GET,    KEY_MIN, '0);
        queue_item(OP_GET,    KEY_MAX, '0);
        queue_item(OP_PUT,    KEY_MAX, 32'sh5A5A_A5A5);
        queue_item(OP_GET,    KEY_MAX, -32'sd1);
        queue_item(OP_DUMP,   32'sd9, 32'sd9);
        queue_item(OP_REMOVE, '0, '0);
        queue_item(OP_REMOVE, '0, '0);
        queue_item(OP_GET,    '0, '0);
        queue_item(OP_GET,    -32'sd1, '0);
        queue_item(OP_DUMP,   '0, '0);
        queue_item(OP_REMOVE, KEY_MIN, '0);
        queue_item(OP_REMOVE, KEY_MAX, '0);
        queue_item(OP_REMOVE, -32'sd1, '0);
        queue_item(OP_REMOVE, 32'sd1, '0);
        queue_item(OP_DUMP,   -32'sd1, -32'sd1);

        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = -32'sd1;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // Random: fill runs that reach a full table, drain runs and mixed bursts.
        generated  = 0;
        fill_first = 1'b1;
        while (generated < RANDOM_ITEMS) begin
            kind = fill_first ? 1 : $urandom_range(0, 4);
            fill_first = 1'b0;
            case (kind)
                1: begin
                    start = $urandom_range(0, POOL_SIZE - 1);
                    for (int j = 0; j < 18; j++)
                        queue_item(OP_PUT, key_pool[(start + j) % POOL_SIZE], $urandom);
                    queue_item(OP_PUT, $urandom, $urandom);
                    queue_item(OP_DUMP, $urandom, $urandom);
                    generated += 20;
                end
                2: begin
                    for (int j = 0; j < 10; j++)
                        queue_item(OP_REMOVE, pick_key(), $urandom);
                    queue_item(OP_DUMP, $urandom, $urandom);
                    generated += 11;
                end
                default: begin
                    start = $urandom_range(8, 15);
                    for (int j = 0; j < start; j++) begin
                        kind = $urandom_range(0, 99);
                        if (kind < 40)
                            queue_item(OP_PUT, pick_key(), $urandom);
                        else if (kind < 65)
                            queue_item(OP_GET, pick_key(), $urandom);
                        else if (kind < 85)
                            queue_item(OP_REMOVE, pick_key(), $urandom);
                        else
                            queue_item(OP_DUMP, $urandom, $urandom);
                    end
                    generated += start;
                end
            endcase
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d put, %0d get, %0d remove and %0d dump items; %0d results checked.",
                 put_count, get_count, remove_count, dump_count, results_checked);
        $display("Saw %0d puts refused on a full table and %0d dumps of an empty table.",
                 full_refusals, empty_dumps);
        if (mismatches == 0) begin
            $display("** sorted_key_value_table_unit: PASSED **");
        end else begin
            $display("%0d mismatching or unexpected results.", mismatches);
            $display("** sorted_key_value_table_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("Timeout with %0d items pending and %0d results outstanding.",
                 pending_items.size(), expected_results.size());
        $display("** sorted_key_value_table_unit: FAILED **");
        $finish;
    end

endmodule
